>>> hdl/md5_digest_engine_assert.svh
// Assertion macros shared by the MD5 digest engine RTL.
// Include with the bare file name; define NO_ASSERTIONS to compile them out.
`ifndef MD5_DIGEST_ENGINE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define MDE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("md5 engine assertion failed");
// Checked at every edge, reset included.
`define MDE_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("md5 engine assertion failed");
`else
`define MDE_ASSERT(label, clk, rst_n, prop)
`define MDE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/md5_pkg.sv
// Shared types, constants and table functions of the MD5 digest engine.
// No dependencies; used by md5_round, md5_compress and md5_digest_engine.
`default_nettype none

package md5_pkg;

	typedef logic [31:0] word_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hEFCDAB89;
	localparam word_t IV_C = 32'h98BADCFE;
	localparam word_t IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned LEN_W = 61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FULL_GO,
		ST_FULL_WAIT,
		ST_PAD,
		ST_PAD1_WAIT,
		ST_LEN,
		ST_FINAL_WAIT,
		ST_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SETUP,
		CS_ROUND,
		CS_ADD
	} cmp_state_t;

	typedef struct packed {
		logic start;
		logic reinit;
	} cmp_ctrl_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [3:0] msg_idx;
	} cmp_stat_t;

	function automatic word_t rotl32(input word_t x, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {x, x} << s;
		return dbl[63:32];
	endfunction

	function automatic logic [4:0] rot_amount(input logic [3:0] sel);
		logic [4:0] r;
		case (sel)
			4'd0: r = 5'd7;
			4'd1: r = 5'd12;
			4'd2: r = 5'd17;
			4'd3: r = 5'd22;
			4'd4: r = 5'd5;
			4'd5: r = 5'd9;
			4'd6: r = 5'd14;
			4'd7: r = 5'd20;
			4'd8: r = 5'd4;
			4'd9: r = 5'd11;
			4'd10: r = 5'd16;
			4'd11: r = 5'd23;
			4'd12: r = 5'd6;
			4'd13: r = 5'd10;
			4'd14: r = 5'd15;
			default: r = 5'd21;
		endcase
		return r;
	endfunction

	// Message word taken by a given step.
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] r;
		logic [3:0] lo;
		lo = i[3:0];
		case (i[5:4])
			2'd0: r = lo;
			2'd1: r = lo * 4'd5 + 4'd1;
			2'd2: r = lo * 4'd3 + 4'd5;
			default: r = lo * 4'd7;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		word_t r;
		case (i)
			6'd0: r = 32'hd76aa478;
			6'd1: r = 32'he8c7b756;
			6'd2: r = 32'h242070db;
			6'd3: r = 32'hc1bdceee;
			6'd4: r = 32'hf57c0faf;
			6'd5: r = 32'h4787c62a;
			6'd6: r = 32'ha8304613;
			6'd7: r = 32'hfd469501;
			6'd8: r = 32'h698098d8;
			6'd9: r = 32'h8b44f7af;
			6'd10: r = 32'hffff5bb1;
			6'd11: r = 32'h895cd7be;
			6'd12: r = 32'h6b901122;
			6'd13: r = 32'hfd987193;
			6'd14: r = 32'ha679438e;
			6'd15: r = 32'h49b40821;
			6'd16: r = 32'hf61e2562;
			6'd17: r = 32'hc040b340;
			6'd18: r = 32'h265e5a51;
			6'd19: r = 32'he9b6c7aa;
			6'd20: r = 32'hd62f105d;
			6'd21: r = 32'h02441453;
			6'd22: r = 32'hd8a1e681;
			6'd23: r = 32'he7d3fbc8;
			6'd24: r = 32'h21e1cde6;
			6'd25: r = 32'hc33707d6;
			6'd26: r = 32'hf4d50d87;
			6'd27: r = 32'h455a14ed;
			6'd28: r = 32'ha9e3e905;
			6'd29: r = 32'hfcefa3f8;
			6'd30: r = 32'h676f02d9;
			6'd31: r = 32'h8d2a4c8a;
			6'd32: r = 32'hfffa3942;
			6'd33: r = 32'h8771f681;
			6'd34: r = 32'h6d9d6122;
			6'd35: r = 32'hfde5380c;
			6'd36: r = 32'ha4beea44;
			6'd37: r = 32'h4bdecfa9;
			6'd38: r = 32'hf6bb4b60;
			6'd39: r = 32'hbebfbc70;
			6'd40: r = 32'h289b7ec6;
			6'd41: r = 32'heaa127fa;
			6'd42: r = 32'hd4ef3085;
			6'd43: r = 32'h04881d05;
			6'd44: r = 32'hd9d4d039;
			6'd45: r = 32'he6db99e5;
			6'd46: r = 32'h1fa27cf8;
			6'd47: r = 32'hc4ac5665;
			6'd48: r = 32'hf4292244;
			6'd49: r = 32'h432aff97;
			6'd50: r = 32'hab9423a7;
			6'd51: r = 32'hfc93a039;
			6'd52: r = 32'h655b59c3;
			6'd53: r = 32'h8f0ccc92;
			6'd54: r = 32'hffeff47d;
			6'd55: r = 32'h85845dd1;
			6'd56: r = 32'h6fa87e4f;
			6'd57: r = 32'hfe2ce6e0;
			6'd58: r = 32'ha3014314;
			6'd59: r = 32'h4e0811a1;
			6'd60: r = 32'hf7537e82;
			6'd61: r = 32'hbd3af235;
			6'd62: r = 32'h2ad7d2bb;
			default: r = 32'heb86d391;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/md5_digest_engine.sv
// MD5 digest engine top level: byte collection, padding control, digest output.
// Depends on md5_pkg, md5_compress (with md5_round) and md5_digest_engine_assert.svh.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, data_byte, has_byte,  | into block
//           | msg_last                                  |
//   out     | out_valid, out_stall, digest_word,        | out of block
//           | word_index, digest_last                   |
//
// A byte item that neither completes a 64-byte block nor ends the message leaves the engine idle.
// A 64th byte runs a compression: start, setup, 64 steps on the single shared
// step unit, chaining add; input stays stalled until the chaining add is done.
// The final item adds one or two padded compressions (the PAD or LEN state of each
// loads the padded block and starts the step unit), then four digest items,
// one per cycle unstalled.
// Reset loads the initial vector and clears fill count and length; block data
// is left as is. in_stall is high whenever the engine is busy or emitting.
`default_nettype none

`include "md5_digest_engine_assert.svh"

module md5_digest_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        msg_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             digest_last
);

	md5_pkg::top_state_t  state_q, state_d;
	logic [5:0]           fill_q;
	logic [md5_pkg::LEN_W-1:0] total_q;
	logic                 last_pend_q;
	logic [1:0]           word_q;
	md5_pkg::word_t [md5_pkg::BLOCK_WORDS-1:0] blk_q;
	md5_pkg::word_t [md5_pkg::BLOCK_WORDS-1:0] pad_blk;
	md5_pkg::word_t [md5_pkg::BLOCK_WORDS-1:0] len_blk;
	md5_pkg::word_t [3:0] chain;
	md5_pkg::cmp_ctrl_t   ctrl;
	md5_pkg::cmp_stat_t   stat;
	logic                 in_acc;
	logic                 out_acc;
	logic                 fill_short;
	md5_pkg::word_t       len_lo, len_hi;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	md5_compress u_compress (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.msg_word (blk_q[stat.msg_idx]),
		.stat     (stat),
		.chain    (chain)
	);

	// bit length, little-endian across words 14 and 15
	assign len_lo     = {total_q[28:0], 3'b000};
	assign len_hi     = total_q[60:29];
	// room left for the length in the padded block
	assign fill_short = (fill_q[5:3] != 3'b111);

	// Padding: keep message bytes, mark the first free byte, zero the rest.
	always_comb begin
		for (int p = 0; p < 64; p++) begin
			if (6'(p) < fill_q) begin
				pad_blk[p/4][8*(p%4) +: 8] = blk_q[p/4][8*(p%4) +: 8];
			end else if (6'(p) == fill_q) begin
				pad_blk[p/4][8*(p%4) +: 8] = md5_pkg::PAD_BYTE;
			end else begin
				pad_blk[p/4][8*(p%4) +: 8] = 8'h00;
			end
		end
		if (fill_short) begin
			pad_blk[14] = len_lo;
			pad_blk[15] = len_hi;
		end
	end

	always_comb begin
		len_blk     = '0;
		len_blk[14] = len_lo;
		len_blk[15] = len_hi;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (has_byte && fill_q == 6'd63) state_d = md5_pkg::ST_FULL_GO;
					else if (msg_last) state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_FULL_GO: state_d = md5_pkg::ST_FULL_WAIT;
			md5_pkg::ST_FULL_WAIT: begin
				if (stat.done) state_d = last_pend_q ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
			end
			md5_pkg::ST_PAD: begin
				state_d = fill_short ? md5_pkg::ST_FINAL_WAIT : md5_pkg::ST_PAD1_WAIT;
			end
			md5_pkg::ST_PAD1_WAIT: begin
				if (stat.done) state_d = md5_pkg::ST_LEN;
			end
			md5_pkg::ST_LEN: state_d = md5_pkg::ST_FINAL_WAIT;
			md5_pkg::ST_FINAL_WAIT: begin
				if (stat.done) state_d = md5_pkg::ST_OUT;
			end
			md5_pkg::ST_OUT: begin
				if (out_acc && word_q == 2'd3) state_d = md5_pkg::ST_IDLE;
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall    = (state_q != md5_pkg::ST_IDLE);
		out_valid   = (state_q == md5_pkg::ST_OUT);
		ctrl.start  = (state_q == md5_pkg::ST_FULL_GO) || (state_q == md5_pkg::ST_PAD) ||
			(state_q == md5_pkg::ST_LEN);
		ctrl.reinit = out_acc && (word_q == 2'd3);
		digest_word = chain[word_q];
		word_index  = word_q;
		digest_last = (word_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5_pkg::ST_IDLE;
			fill_q      <= '0;
			total_q     <= '0;
			last_pend_q <= 1'b0;
			word_q      <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				last_pend_q <= msg_last;
				if (has_byte) begin
					fill_q  <= fill_q + 6'd1;
					total_q <= total_q + 61'd1;
				end
			end
			if (out_acc) begin
				word_q <= word_q + 2'd1;
				if (word_q == 2'd3) begin
					fill_q  <= '0;
					total_q <= '0;
				end
			end
		end
	end

	// Message block: write a byte lane, or load a padded block.
	always_ff @(posedge clk) begin
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (in_acc && has_byte) blk_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= data_byte;
			end
			md5_pkg::ST_PAD: blk_q <= pad_blk;
			md5_pkg::ST_LEN: blk_q <= len_blk;
			default: begin
			end
		endcase
	end

	`MDE_ASSERT(a_start_when_idle, clk, arst_n, ctrl.start |-> !stat.busy)
	`MDE_ASSERT(a_fill_advances, clk, arst_n, (in_acc && has_byte) |=> (fill_q == $past(fill_q) + 6'd1))
	`MDE_ASSERT(a_plain_byte_one_cycle, clk, arst_n, (in_acc && has_byte && !msg_last && fill_q != 6'd63) |=> !in_stall)
	`MDE_ASSERT(a_iv_after_digest, clk, arst_n, (out_acc && word_q == 2'd3) |=> (chain[0] == md5_pkg::IV_A && chain[3] == md5_pkg::IV_D))

endmodule

`default_nettype wire

>>> hdl/md5_round.sv
// One MD5 step: boolean function, add, rotate and add into B.
// Depends on md5_pkg.
`default_nettype none

module md5_round (
	input  wire logic [5:0]    rnd,
	input  wire md5_pkg::word_t b,
	input  wire md5_pkg::word_t c,
	input  wire md5_pkg::word_t d,
	input  wire md5_pkg::word_t pre,
	output md5_pkg::word_t      new_b
);

	md5_pkg::word_t f;
	md5_pkg::word_t sum;
	logic [4:0]     shamt;

	always_comb begin
		case (rnd[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
	end

	// pre already holds a + K + M for this step
	assign sum   = f + pre;
	assign shamt = md5_pkg::rot_amount({rnd[5:4], rnd[1:0]});
	assign new_b = b + md5_pkg::rotl32(sum, shamt);

endmodule

`default_nettype wire

>>> hdl/md5_compress.sv
// MD5 compression sequencer: chaining words, working registers, step counter.
// Depends on md5_pkg, md5_round and md5_digest_engine_assert.svh.
`default_nettype none

`include "md5_digest_engine_assert.svh"

module md5_compress (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire md5_pkg::cmp_ctrl_t   ctrl,
	input  wire md5_pkg::word_t       msg_word,
	output md5_pkg::cmp_stat_t        stat,
	output md5_pkg::word_t [3:0]      chain
);

	md5_pkg::cmp_state_t state_q, state_d;
	logic [5:0]          rnd_q;
	logic [5:0]          nxt_rnd;
	md5_pkg::word_t      a_q, b_q, c_q, d_q, pre_q;
	md5_pkg::word_t      chain_q [4];
	md5_pkg::word_t      new_b;
	md5_pkg::word_t      pre_base;

	md5_round u_round (
		.rnd   (rnd_q),
		.b     (b_q),
		.c     (c_q),
		.d     (d_q),
		.pre   (pre_q),
		.new_b (new_b)
	);

	// next step index whose message word is fetched this cycle
	assign nxt_rnd  = (state_q == md5_pkg::CS_ROUND) ? rnd_q + 6'd1 : 6'd0;
	assign pre_base = (state_q == md5_pkg::CS_ROUND) ? d_q : a_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			md5_pkg::CS_IDLE: begin
				if (ctrl.start) state_d = md5_pkg::CS_SETUP;
			end
			md5_pkg::CS_SETUP: state_d = md5_pkg::CS_ROUND;
			md5_pkg::CS_ROUND: begin
				if (rnd_q == 6'd63) state_d = md5_pkg::CS_ADD;
			end
			md5_pkg::CS_ADD: state_d = md5_pkg::CS_IDLE;
			default: state_d = md5_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		stat.busy    = (state_q != md5_pkg::CS_IDLE);
		stat.done    = (state_q == md5_pkg::CS_ADD);
		stat.msg_idx = md5_pkg::msg_index(nxt_rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= md5_pkg::CS_IDLE;
			rnd_q      <= '0;
			chain_q[0] <= md5_pkg::IV_A;
			chain_q[1] <= md5_pkg::IV_B;
			chain_q[2] <= md5_pkg::IV_C;
			chain_q[3] <= md5_pkg::IV_D;
		end else begin
			state_q <= state_d;
			if (state_q == md5_pkg::CS_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == md5_pkg::CS_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end else if (ctrl.reinit) begin
				chain_q[0] <= md5_pkg::IV_A;
				chain_q[1] <= md5_pkg::IV_B;
				chain_q[2] <= md5_pkg::IV_C;
				chain_q[3] <= md5_pkg::IV_D;
			end
		end
	end

	// working registers: payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			md5_pkg::CS_IDLE: begin
				if (ctrl.start) begin
					a_q <= chain_q[0];
					b_q <= chain_q[1];
					c_q <= chain_q[2];
					d_q <= chain_q[3];
				end
			end
			md5_pkg::CS_SETUP: begin
				pre_q <= pre_base + md5_pkg::round_k(nxt_rnd) + msg_word;
			end
			md5_pkg::CS_ROUND: begin
				a_q   <= d_q;
				d_q   <= c_q;
				c_q   <= b_q;
				b_q   <= new_b;
				pre_q <= pre_base + md5_pkg::round_k(nxt_rnd) + msg_word;
			end
			default: begin
			end
		endcase
	end

	assign chain[0] = chain_q[0];
	assign chain[1] = chain_q[1];
	assign chain[2] = chain_q[2];
	assign chain[3] = chain_q[3];

	`MDE_ASSERT(a_last_step_adds, clk, arst_n, (state_q == md5_pkg::CS_ROUND && rnd_q == 6'd63) |=> (state_q == md5_pkg::CS_ADD))
	`MDE_ASSERT(a_add_then_idle, clk, arst_n, (state_q == md5_pkg::CS_ADD) |=> (state_q == md5_pkg::CS_IDLE && rnd_q == 6'd0))

endmodule

`default_nettype wire
